>>> hw/rtl/fxd_pkg.sv
// Shared types and constants for the framed XOR packet deframer.
package fxd_pkg;

  // Frame layout: start, length, command, payload, xor, end.
  localparam int unsigned FRAME_OVH = 5;
  localparam int unsigned MIN_FILL  = 5;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PL_W   = 6;

  // Configuration register indexes.
  localparam logic CFG_START_IDX = 1'b0;
  localparam logic CFG_END_IDX   = 1'b1;

  localparam logic [BYTE_W-1:0] START_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_RST   = 8'h03;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] data;
    logic [PL_W-1:0]   payload_length;
    logic              last;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_LEN,
    S_END,
    S_CMD,
    S_XOR,
    S_HDR,
    S_PAY,
    S_ERR,
    S_DROP
  } state_t;

endpackage

>>> hw/rtl/fxd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fxd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 37
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/fxd_ctrl.sv
// Sequencer that buffers bytes in a ring memory and parses frames out of it.
module fxd_ctrl #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [fxd_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       in_ready,
  input  logic [fxd_pkg::BYTE_W-1:0] start_byte,
  input  logic [fxd_pkg::BYTE_W-1:0] end_byte,
  input  logic                       slot_free,
  output logic                       emit_valid,
  output fxd_pkg::item_t             emit_item
);

  localparam int unsigned DEPTH = MAX_PAYLOAD + fxd_pkg::FRAME_OVH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  fxd_pkg::state_t state_r, state_nxt;

  logic [PTR_W-1:0]          head_r, head_nxt;
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic [CNT_W-1:0]          len_r, len_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic [fxd_pkg::BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [fxd_pkg::BYTE_W-1:0] xor_r, xor_nxt;

  logic                       wr_en;
  logic [PTR_W-1:0]           wr_addr;
  logic                       rd_en;
  logic [CNT_W-1:0]           rd_off;
  logic [PTR_W-1:0]           rd_addr;
  logic [fxd_pkg::BYTE_W-1:0] rd_data;

  logic [CNT_W-1:0] total;
  logic [8:0]       total_len;
  logic             too_long;
  logic             too_short;

  // Ring address: base plus an offset below twice the depth, folded once.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = {2'b00, base} + {1'b0, off};
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  assign rd_addr   = wrap_add(head_r, rd_off);
  assign total     = len_r + CNT_W'(fxd_pkg::FRAME_OVH);
  assign total_len = {1'b0, rd_data} + 9'(fxd_pkg::FRAME_OVH);
  assign too_long  = rd_data > fxd_pkg::BYTE_W'(MAX_PAYLOAD);
  assign too_short = 9'(fill_r) < total_len;
  assign in_ready  = (state_r == fxd_pkg::S_IDLE);

  fxd_ram #(
    .WIDTH(fxd_pkg::BYTE_W),
    .DEPTH(DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(in_rx_byte),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fxd_pkg::S_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    idx_r <= idx_nxt;
    cmd_r <= cmd_nxt;
    xor_r <= xor_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    cmd_nxt    = cmd_r;
    xor_nxt    = xor_r;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    rd_en      = 1'b0;
    rd_off     = '0;
    emit_valid = 1'b0;
    emit_item  = '{kind: fxd_pkg::KIND_HDR, command: cmd_r, data: '0,
                   payload_length: fxd_pkg::PL_W'(len_r), last: 1'b0};

    unique case (state_r)
      fxd_pkg::S_IDLE: begin
        if (in_valid) begin
          wr_en     = 1'b1;
          state_nxt = fxd_pkg::S_CHECK;
          if (fill_r == CNT_W'(DEPTH)) begin
            // A full ring loses its oldest byte; the new one takes its slot.
            wr_addr  = head_r;
            head_nxt = wrap_add(head_r, CNT_W'(1));
          end else begin
            wr_addr  = wrap_add(head_r, fill_r);
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
      end

      fxd_pkg::S_CHECK: begin
        if (fill_r < CNT_W'(fxd_pkg::MIN_FILL)) begin
          state_nxt = fxd_pkg::S_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = fxd_pkg::S_SCAN;
        end
      end

      fxd_pkg::S_SCAN: begin
        if (rd_data != start_byte) begin
          // Drop the byte and, if any bytes remain, look at the next one.
          head_nxt = wrap_add(head_r, CNT_W'(1));
          fill_nxt = fill_r - CNT_W'(1);
          if (fill_r == CNT_W'(1)) begin
            state_nxt = fxd_pkg::S_IDLE;
          end else begin
            rd_en  = 1'b1;
            rd_off = CNT_W'(1);
          end
        end else if (fill_r < CNT_W'(fxd_pkg::MIN_FILL)) begin
          state_nxt = fxd_pkg::S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_off    = CNT_W'(1);
          state_nxt = fxd_pkg::S_LEN;
        end
      end

      fxd_pkg::S_LEN: begin
        if (too_long) begin
          head_nxt  = wrap_add(head_r, CNT_W'(1));
          fill_nxt  = fill_r - CNT_W'(1);
          state_nxt = fxd_pkg::S_CHECK;
        end else if (too_short) begin
          state_nxt = fxd_pkg::S_IDLE;
        end else begin
          len_nxt   = CNT_W'(rd_data);
          rd_en     = 1'b1;
          rd_off    = CNT_W'(rd_data) + CNT_W'(fxd_pkg::FRAME_OVH - 1);
          state_nxt = fxd_pkg::S_END;
        end
      end

      fxd_pkg::S_END: begin
        if (rd_data != end_byte) begin
          head_nxt  = wrap_add(head_r, CNT_W'(1));
          fill_nxt  = fill_r - CNT_W'(1);
          state_nxt = fxd_pkg::S_CHECK;
        end else begin
          rd_en     = 1'b1;
          rd_off    = CNT_W'(2);
          state_nxt = fxd_pkg::S_CMD;
        end
      end

      fxd_pkg::S_CMD: begin
        cmd_nxt   = rd_data;
        xor_nxt   = rd_data;
        idx_nxt   = '0;
        rd_en     = 1'b1;
        rd_off    = CNT_W'(3);
        state_nxt = fxd_pkg::S_XOR;
      end

      fxd_pkg::S_XOR: begin
        // rd_data holds the byte at offset three plus idx_r; at idx_r equal
        // to the length that byte is the transmitted checksum.
        if (idx_r == len_r) begin
          if (xor_r == rd_data) begin
            state_nxt = fxd_pkg::S_HDR;
          end else begin
            state_nxt = fxd_pkg::S_ERR;
          end
        end else begin
          xor_nxt = xor_r ^ rd_data;
          idx_nxt = idx_r + CNT_W'(1);
          rd_en   = 1'b1;
          rd_off  = idx_r + CNT_W'(4);
        end
      end

      fxd_pkg::S_HDR: begin
        if (slot_free) begin
          emit_valid     = 1'b1;
          emit_item.last = (len_r == '0);
          if (len_r == '0) begin
            state_nxt = fxd_pkg::S_DROP;
          end else begin
            idx_nxt   = '0;
            rd_en     = 1'b1;
            rd_off    = CNT_W'(3);
            state_nxt = fxd_pkg::S_PAY;
          end
        end
      end

      fxd_pkg::S_PAY: begin
        if (slot_free) begin
          emit_valid     = 1'b1;
          emit_item.kind = fxd_pkg::KIND_DATA;
          emit_item.data = rd_data;
          emit_item.last = (idx_r + CNT_W'(1) == len_r);
          if (idx_r + CNT_W'(1) == len_r) begin
            state_nxt = fxd_pkg::S_DROP;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
            rd_en   = 1'b1;
            rd_off  = idx_r + CNT_W'(4);
          end
        end
      end

      fxd_pkg::S_ERR: begin
        if (slot_free) begin
          emit_valid     = 1'b1;
          emit_item.kind = fxd_pkg::KIND_ERR;
          emit_item.last = 1'b1;
          state_nxt      = fxd_pkg::S_DROP;
        end
      end

      fxd_pkg::S_DROP: begin
        head_nxt  = wrap_add(head_r, total);
        fill_nxt  = fill_r - total;
        state_nxt = fxd_pkg::S_CHECK;
      end

      default: begin
        state_nxt = fxd_pkg::S_IDLE;
      end
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("buffer fill count beyond ring depth");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit_valid |-> slot_free)
    else $error("item emitted while output register is occupied");

  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=>
      (fill_r == $past(fill_r) + CNT_W'(1)) || ($past(fill_r) == CNT_W'(DEPTH)))
    else $error("accepted byte not counted in the buffer");

  a_last_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_valid && emit_item.last) |=> state_r == fxd_pkg::S_DROP)
    else $error("frame's last item not followed by its removal");

endmodule

>>> hw/rtl/framed_xor_packet_deframer_unit.sv
// Top level of the framed XOR packet deframer: registers, output stage, sequencer.
//
// Bytes enter one transfer at a time, only while the sequencer is idle, and
// are kept in a ring memory of MAX_PAYLOAD+5 entries with a single read
// port; the sequencer walks that memory one byte per cycle, except while it
// waits on out_ready for the output register. Buffered bytes are dropped
// one at a time while hunting for a start byte or recovering from a bad
// length or end byte. A result sits in a single output register, so the
// next frame's work goes on while it waits. The window memory is not
// cleared after reset; only bytes that have been received are ever read.
module framed_xor_packet_deframer_unit #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fxd_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_kind,
  output logic [fxd_pkg::BYTE_W-1:0] out_command,
  output logic [fxd_pkg::BYTE_W-1:0] out_data,
  output logic [fxd_pkg::PL_W-1:0]   out_payload_length,
  output logic                       out_last,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [fxd_pkg::BYTE_W-1:0] cfg_wdata
);

  logic [fxd_pkg::BYTE_W-1:0] start_byte_r;
  logic [fxd_pkg::BYTE_W-1:0] end_byte_r;
  logic                       out_valid_r, out_valid_nxt;
  fxd_pkg::item_t             out_item_r;
  logic                       slot_free;
  logic                       emit_valid;
  fxd_pkg::item_t             emit_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= fxd_pkg::START_RST;
      end_byte_r   <= fxd_pkg::END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fxd_pkg::CFG_START_IDX: start_byte_r <= cfg_wdata;
        fxd_pkg::CFG_END_IDX:   end_byte_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The output register is free when empty or when its transfer completes now.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      out_item_r <= emit_item;
    end
  end

  fxd_ctrl #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_rx_byte(in_rx_byte),
    .in_ready  (in_ready),
    .start_byte(start_byte_r),
    .end_byte  (end_byte_r),
    .slot_free (slot_free),
    .emit_valid(emit_valid),
    .emit_item (emit_item)
  );

  assign out_valid          = out_valid_r;
  assign out_kind           = out_item_r.kind;
  assign out_command        = out_item_r.command;
  assign out_data           = out_item_r.data;
  assign out_payload_length = out_item_r.payload_length;
  assign out_last           = out_item_r.last;

endmodule

>>> tb/framed_xor_packet_deframer_unit_test.sv
// Self-checking testbench for the framed XOR packet deframer.
module framed_xor_packet_deframer_unit_test;

  localparam int unsigned MAX_PAYLOAD  = 32;
  localparam int unsigned WIN_DEPTH    = MAX_PAYLOAD + fxd_pkg::FRAME_OVH;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned TIMEOUT      = 5_000_000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [fxd_pkg::BYTE_W-1:0] in_rx_byte = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 out_kind;
  logic [fxd_pkg::BYTE_W-1:0] out_command;
  logic [fxd_pkg::BYTE_W-1:0] out_data;
  logic [fxd_pkg::PL_W-1:0]   out_payload_length;
  logic                       out_last;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [fxd_pkg::BYTE_W-1:0] cfg_wdata = '0;

  // Stimulus and prediction state.
  logic [fxd_pkg::BYTE_W-1:0] pending_bytes[$];
  logic [fxd_pkg::BYTE_W-1:0] rx_window[$];
  fxd_pkg::item_t             expected_items[$];
  logic [fxd_pkg::BYTE_W-1:0] frame_start = fxd_pkg::START_RST;
  logic [fxd_pkg::BYTE_W-1:0] frame_end = fxd_pkg::END_RST;
  int unsigned                queued_bytes = 0;
  int unsigned                mismatches = 0;
  logic                       in_took = 1'b0;
  logic                       steady = 1'b0;

  framed_xor_packet_deframer_unit #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_command(out_command),
    .out_data(out_data),
    .out_payload_length(out_payload_length),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic fxd_pkg::item_t make_item(fxd_pkg::kind_t k,
                                               logic [fxd_pkg::BYTE_W-1:0] cmd,
                                               logic [fxd_pkg::BYTE_W-1:0] data,
                                               int unsigned len, logic last);
    fxd_pkg::item_t it;
    it.kind = k;
    it.command = cmd;
    it.data = data;
    it.payload_length = fxd_pkg::PL_W'(len);
    it.last = last;
    return it;
  endfunction

  function automatic void expect_item(fxd_pkg::item_t it);
    expected_items = {expected_items, it};
  endfunction

  // Appends one received byte to the window and emits every frame it completes.
  function automatic void deframe_byte(logic [fxd_pkg::BYTE_W-1:0] b);
    int unsigned len;
    int unsigned total;
    logic [fxd_pkg::BYTE_W-1:0] cmd;
    logic [fxd_pkg::BYTE_W-1:0] sum;
    if (rx_window.size() >= WIN_DEPTH) void'(rx_window.pop_front());
    rx_window = {rx_window, b};
    while (rx_window.size() >= fxd_pkg::FRAME_OVH) begin
      while (rx_window.size() > 0 && rx_window[0] != frame_start)
        void'(rx_window.pop_front());
      if (rx_window.size() < fxd_pkg::FRAME_OVH) break;
      len = rx_window[1];
      if (len > MAX_PAYLOAD) begin
        void'(rx_window.pop_front());
        continue;
      end
      total = len + fxd_pkg::FRAME_OVH;
      if (rx_window.size() < total) break;
      if (rx_window[total-1] != frame_end) begin
        void'(rx_window.pop_front());
        continue;
      end
      cmd = rx_window[2];
      sum = cmd;
      for (int unsigned i = 0; i < len; i++) sum ^= rx_window[3+i];
      if (sum == rx_window[3+len]) begin
        expect_item(make_item(fxd_pkg::KIND_HDR, cmd, '0, len, len == 0));
        for (int unsigned i = 0; i < len; i++)
          expect_item(make_item(fxd_pkg::KIND_DATA, cmd, rx_window[3+i], len,
                                i + 1 == len));
      end else begin
        expect_item(make_item(fxd_pkg::KIND_ERR, cmd, '0, len, 1'b1));
      end
      repeat (total) void'(rx_window.pop_front());
    end
  endfunction

  function automatic void queue_byte(logic [fxd_pkg::BYTE_W-1:0] b);
    pending_bytes = {pending_bytes, b};
    queued_bytes++;
  endfunction

  function automatic logic [fxd_pkg::BYTE_W-1:0] pick_other(
      logic [fxd_pkg::BYTE_W-1:0] a, logic [fxd_pkg::BYTE_W-1:0] b);
    logic [fxd_pkg::BYTE_W-1:0] v;
    v = fxd_pkg::BYTE_W'($urandom);
    while (v == a || v == b) v = fxd_pkg::BYTE_W'($urandom);
    return v;
  endfunction

  function automatic int unsigned pick_len();
    if ($urandom_range(0, 15) == 0) return MAX_PAYLOAD;
    return $urandom_range(0, 6);
  endfunction

  function automatic void push_frame(int unsigned len, bit bad_sum, bit bad_tail);
    logic [fxd_pkg::BYTE_W-1:0] cmd;
    logic [fxd_pkg::BYTE_W-1:0] sum;
    logic [fxd_pkg::BYTE_W-1:0] b;
    cmd = fxd_pkg::BYTE_W'($urandom);
    sum = cmd;
    queue_byte(frame_start);
    queue_byte(fxd_pkg::BYTE_W'(len));
    queue_byte(cmd);
    for (int unsigned i = 0; i < len; i++) begin
      b = fxd_pkg::BYTE_W'($urandom);
      sum ^= b;
      queue_byte(b);
    end
    if (bad_sum) sum ^= fxd_pkg::BYTE_W'($urandom_range(1, 255));
    queue_byte(sum);
    queue_byte(bad_tail ? frame_end ^ fxd_pkg::BYTE_W'($urandom_range(1, 255))
                        : frame_end);
  endfunction

  // A bogus header whose length swallows one or two real frames; the wrong
  // closing byte forces a resync that releases them all in one transfer.
  function automatic void push_nested();
    int unsigned inner_len[2];
    int unsigned n;
    int unsigned inner_bytes;
    int unsigned fake_len;
    n = $urandom_range(1, 2);
    inner_bytes = 0;
    for (int unsigned i = 0; i < n; i++) begin
      inner_len[i] = $urandom_range(0, 3);
      inner_bytes += inner_len[i] + fxd_pkg::FRAME_OVH;
    end
    fake_len = inner_bytes + $urandom_range(1, 6);
    queue_byte(frame_start);
    queue_byte(fxd_pkg::BYTE_W'(fake_len));
    for (int unsigned i = 0; i < n; i++) push_frame(inner_len[i], 1'b0, 1'b0);
    for (int unsigned i = inner_bytes + 2; i < fake_len + fxd_pkg::FRAME_OVH; i++)
      queue_byte(pick_other(frame_start, frame_end));
  endfunction

  function automatic void random_traffic(int unsigned budget);
    int unsigned stop;
    int unsigned pick;
    stop = queued_bytes + budget;
    while (queued_bytes < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) push_frame(pick_len(), 1'b0, 1'b0);
      else if (pick < 65) push_frame(pick_len(), 1'b1, 1'b0);
      else if (pick < 73) push_frame(pick_len(), 1'b0, 1'b1);
      else if (pick < 80) begin
        queue_byte(frame_start);
        queue_byte(fxd_pkg::BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255)));
      end else if (pick < 88) push_nested();
      else repeat ($urandom_range(1, 6)) queue_byte(fxd_pkg::BYTE_W'($urandom));
    end
  endfunction

  task automatic write_reg(logic idx, logic [fxd_pkg::BYTE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == fxd_pkg::CFG_START_IDX) frame_start = v;
    else frame_end = v;
  endtask

  // Waits until every byte is in and every predicted result is out, then
  // gives the sequencer time to finish any resync that produces nothing.
  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid || expected_items.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (pending_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 9)) begin
          in_valid <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= steady || $urandom_range(0, 99) >= 9;
    end
  end

  always @(posedge clk) begin
    fxd_pkg::item_t got;
    fxd_pkg::item_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) deframe_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        got = make_item(fxd_pkg::kind_t'(out_kind), out_command, out_data,
                        out_payload_length, out_last);
        if (expected_items.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind=%0d cmd=%h data=%h len=%0d last=%b",
                     got.kind, got.command, got.data, got.payload_length, got.last);
        end else begin
          want = expected_items.pop_front();
          if (got.kind !== want.kind || got.command !== want.command ||
              got.data !== want.data || got.payload_length !== want.payload_length ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected kind=%0d cmd=%h data=%h len=%0d last=%b, ",
                        "got kind=%0d cmd=%h data=%h len=%0d last=%b"},
                       want.kind, want.command, want.data, want.payload_length,
                       want.last, got.kind, got.command, got.data,
                       got.payload_length, got.last);
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values of the start and end bytes are used first.
    // Bad checksum on a one-byte payload.
    queue_byte(fxd_pkg::START_RST); queue_byte(8'h01); queue_byte(8'hFF);
    queue_byte(8'h00); queue_byte(8'h5A); queue_byte(fxd_pkg::END_RST);
    // Five bytes without any start byte are discarded as a block.
    queue_byte(8'h00); queue_byte(8'hFF); queue_byte(8'h80);
    queue_byte(8'h7F); queue_byte(8'h01);
    // A length of 255 is a framing error.
    queue_byte(fxd_pkg::START_RST); queue_byte(8'hFF);
    // A fake header spans an empty frame and a one-byte frame, then closes wrong.
    queue_byte(fxd_pkg::START_RST); queue_byte(8'h0A);
    queue_byte(fxd_pkg::START_RST); queue_byte(8'h00); queue_byte(8'h55);
    queue_byte(8'h55); queue_byte(fxd_pkg::END_RST);
    queue_byte(fxd_pkg::START_RST); queue_byte(8'h01); queue_byte(8'h66);
    queue_byte(8'h77); queue_byte(8'h11); queue_byte(fxd_pkg::END_RST);
    queue_byte(8'h00); queue_byte(8'h00);
    random_traffic(20);
    settle();

    write_reg(fxd_pkg::CFG_START_IDX, 8'h00);
    write_reg(fxd_pkg::CFG_END_IDX, 8'hFF);
    random_traffic(25);
    settle();

    // This phase runs with both sides always ready.
    write_reg(fxd_pkg::CFG_START_IDX, 8'hFF);
    write_reg(fxd_pkg::CFG_END_IDX, 8'h00);
    steady <= 1'b1;
    random_traffic(25);
    settle();
    steady <= 1'b0;

    write_reg(fxd_pkg::CFG_START_IDX, 8'h7E);
    write_reg(fxd_pkg::CFG_END_IDX, 8'h7E);
    random_traffic(25);
    settle();

    write_reg(fxd_pkg::CFG_START_IDX, fxd_pkg::BYTE_W'($urandom));
    write_reg(fxd_pkg::CFG_END_IDX, fxd_pkg::BYTE_W'($urandom));
    random_traffic(25);
    settle();

    write_reg(fxd_pkg::CFG_START_IDX, fxd_pkg::START_RST);
    write_reg(fxd_pkg::CFG_END_IDX, fxd_pkg::END_RST);
    random_traffic(25);
    settle();

    if (mismatches == 0 && expected_items.size() == 0)
      $display("framed_xor_packet_deframer_unit regression: pass");
    else
      $display("framed_xor_packet_deframer_unit regression: fail");
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("framed_xor_packet_deframer_unit regression: fail");
    $finish;
  end

endmodule

>>> framed_xor_packet_deframer_unit.f
hw/rtl/fxd_pkg.sv
hw/rtl/fxd_ram.sv
hw/rtl/fxd_ctrl.sv
hw/rtl/framed_xor_packet_deframer_unit.sv
tb/framed_xor_packet_deframer_unit_test.sv
